>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_HOLD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> rtl/i2cms_pkg.sv
// Package: types and codes of the I2C master bit sequencer.
`default_nettype none
package i2cms_pkg;

    localparam int unsigned AttemptW = 4;
    localparam int unsigned BitCntW  = 4;
    localparam int unsigned ByteBits = 8;
    localparam logic [AttemptW-1:0] AttemptsRst = 4'd3;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_RSTART = 3'd1,
        OP_RETRY  = 3'd2,
        OP_STOP   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [4:0] {
        P_IDLE = 5'd0,
        P_ST0  = 5'd1,
        P_ST1  = 5'd2,
        P_ST2  = 5'd3,
        P_ST3  = 5'd4,
        P_WB0  = 5'd5,
        P_WB1  = 5'd6,
        P_WB2  = 5'd7,
        P_WA0  = 5'd8,
        P_WA1  = 5'd9,
        P_WA2  = 5'd10,
        P_SP0  = 5'd11,
        P_SP1  = 5'd12,
        P_SP2  = 5'd13,
        P_RB0  = 5'd14,
        P_RB1  = 5'd15,
        P_RB2  = 5'd16,
        P_RA0  = 5'd17,
        P_RA1  = 5'd18
    } t_phase;

    typedef struct packed {
        logic                cmd_valid;
        logic [2:0]          opcode;
        logic [ByteBits-1:0] tx_byte;
        logic                ack_flag;
        logic                sda_in;
    } t_in_item;

    typedef struct packed {
        logic                scl_level;
        logic                sda_level;
        logic                sda_drive;
        logic                busy_res;
        logic                done_res;
        logic                nack;
        logic [ByteBits-1:0] rx_byte;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/i2cms_in_if.sv
// Interface: tick item channel into the sequencer.
`default_nettype none
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_flag;
    logic       sda_in;

    modport source (output valid, cmd_valid, opcode, tx_byte, ack_flag, sda_in,
                    input ready);
    modport sink   (input valid, cmd_valid, opcode, tx_byte, ack_flag, sda_in,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/i2cms_out_if.sv
// Interface: result item channel out of the sequencer.
`default_nettype none
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       nack;
    logic [7:0] rx_byte;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res,
                    done_res, nack, rx_byte, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res,
                    done_res, nack, rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/i2cms_fsm.sv
// Bus phase sequencer: state registers and per-tick next-state logic.
`default_nettype none
`include "assert_macros.svh"
module i2cms_fsm
    import i2cms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire t_in_item            i_item,
    input  wire logic [AttemptW-1:0] i_max_attempts,
    output t_out_item                o_res
);

    t_phase              r_phase,    n_phase;
    logic [BitCntW-1:0]  r_bit_cnt,  n_bit_cnt;
    logic [ByteBits-1:0] r_shift,    n_shift;
    logic [AttemptW-1:0] r_attempt,  n_attempt;
    logic [2:0]          r_cur_op,   n_cur_op;
    logic                r_sv_ack,   n_sv_ack;
    logic                r_ack_res,  n_ack_res;
    logic [ByteBits-1:0] r_rx_hold,  n_rx_hold;
    logic                r_scl,      n_scl;
    logic                r_sda,      n_sda;
    logic                r_drv,      n_drv;

    t_phase              start_phase;
    logic                busy;
    logic                done;
    logic                nk;
    logic                scl_low_after;
    logic [AttemptW:0]   attempt_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_IDLE;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_attempt <= '0;
            r_cur_op  <= '0;
            r_sv_ack  <= 1'b0;
            r_ack_res <= 1'b0;
            r_rx_hold <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drv     <= 1'b1;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_attempt <= n_attempt;
            r_cur_op  <= n_cur_op;
            r_sv_ack  <= n_sv_ack;
            r_ack_res <= n_ack_res;
            r_rx_hold <= n_rx_hold;
            r_scl     <= scl_low_after ? 1'b0 : n_scl;
            r_sda     <= n_sda;
            r_drv     <= n_drv;
        end
    end

    assign attempt_inc = {1'b0, r_attempt} + {{AttemptW{1'b0}}, 1'b1};

    always_comb begin
        start_phase   = r_phase;
        n_bit_cnt     = r_bit_cnt;
        n_shift       = r_shift;
        n_attempt     = r_attempt;
        n_cur_op      = r_cur_op;
        n_sv_ack      = r_sv_ack;
        n_ack_res     = r_ack_res;
        n_rx_hold     = r_rx_hold;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_drv         = r_drv;
        busy          = 1'b0;
        done          = 1'b0;
        nk            = 1'b0;
        scl_low_after = 1'b0;

        // command pickup while idle
        if (r_phase == P_IDLE && i_item.cmd_valid && i_item.opcode <= OP_READ) begin
            n_cur_op  = i_item.opcode;
            n_shift   = i_item.tx_byte;
            n_sv_ack  = i_item.ack_flag;
            n_attempt = '0;
            n_bit_cnt = '0;
            case (i_item.opcode)
                OP_STOP:  start_phase = P_SP0;
                OP_WRITE: start_phase = P_WB0;
                OP_READ:  start_phase = P_RB0;
                default:  start_phase = P_ST0;
            endcase
        end

        n_phase = start_phase;
        if (start_phase != P_IDLE) begin
            busy = 1'b1;
            case (start_phase)
                P_ST0: begin n_sda = 1'b1; n_phase = P_ST1; end
                P_ST1: begin n_scl = 1'b1; n_phase = P_ST2; end
                P_ST2: begin n_sda = 1'b0; n_phase = P_ST3; end
                P_ST3: begin
                    n_scl     = 1'b0;
                    n_bit_cnt = '0;
                    n_phase   = P_WB0;
                end
                P_WB0: begin
                    n_drv   = 1'b1;
                    n_sda   = n_shift[ByteBits-1];
                    n_phase = P_WB1;
                end
                P_WB1: begin n_scl = 1'b1; n_phase = P_WB2; end
                P_WB2: begin
                    n_scl     = 1'b0;
                    n_shift   = {n_shift[ByteBits-2:0], 1'b0};
                    n_bit_cnt = n_bit_cnt + 1'b1;
                    n_phase   = (n_bit_cnt >= BitCntW'(ByteBits)) ? P_WA0 : P_WB0;
                end
                P_WA0: begin n_drv = 1'b0; n_phase = P_WA1; end
                P_WA1: begin
                    n_scl     = 1'b1;
                    n_ack_res = i_item.sda_in;
                    n_phase   = P_WA2;
                end
                P_WA2: begin
                    n_scl = 1'b0;
                    n_drv = 1'b1;
                    if (n_cur_op == OP_RETRY && n_ack_res) begin
                        n_phase = P_SP0;
                    end else begin
                        done    = 1'b1;
                        nk      = n_ack_res;
                        n_phase = P_IDLE;
                    end
                end
                P_SP0: begin n_sda = 1'b0; n_phase = P_SP1; end
                P_SP1: begin n_scl = 1'b1; n_phase = P_SP2; end
                P_SP2: begin
                    n_sda = 1'b1;
                    if (n_cur_op == OP_RETRY) begin
                        if (attempt_inc >= {1'b0, i_max_attempts}) begin
                            done    = 1'b1;
                            nk      = 1'b1;
                            n_phase = P_IDLE;
                        end else begin
                            n_attempt = attempt_inc[AttemptW-1:0];
                            n_phase   = P_ST0;
                        end
                    end else begin
                        done    = 1'b1;
                        n_phase = P_IDLE;
                    end
                end
                P_RB0: begin
                    n_drv   = 1'b0;
                    n_scl   = 1'b1;
                    n_shift = {n_shift[ByteBits-2:0], i_item.sda_in};
                    n_phase = P_RB1;
                end
                P_RB1: begin n_scl = 1'b1; n_phase = P_RB2; end
                P_RB2: begin
                    n_scl     = 1'b0;
                    n_bit_cnt = n_bit_cnt + 1'b1;
                    n_phase   = (n_bit_cnt >= BitCntW'(ByteBits)) ? P_RA0 : P_RB0;
                end
                P_RA0: begin
                    n_drv   = 1'b1;
                    n_sda   = ~n_sv_ack;
                    n_phase = P_RA1;
                end
                P_RA1: begin
                    n_scl         = 1'b1;
                    scl_low_after = 1'b1;
                    n_rx_hold     = n_shift;
                    done          = 1'b1;
                    n_phase       = P_IDLE;
                end
                default: begin
                    n_phase = P_IDLE;
                    busy    = 1'b0;
                end
            endcase
        end

        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.sda_drive = n_drv;
        o_res.busy_res  = busy;
        o_res.done_res  = done;
        o_res.nack      = done & nk;
        o_res.rx_byte   = n_rx_hold;
    end

    `CHK_HOLD(a_bitcnt_range, i_clk, i_rst_n, r_bit_cnt <= BitCntW'(ByteBits))
    `CHK_HOLD(a_ack_released, i_clk, i_rst_n,
        (i_en && r_phase == P_WA0) |=> (!r_drv && r_phase == P_WA1))

endmodule
`default_nettype wire

>>> rtl/i2c_master_bit_sequencer_unit.sv
// Top level: I2C master bit sequencer with input and result registers.
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    cmd_valid, opcode, tx_byte, ack_flag, sda_in
//   o_item    out   valid/ready    scl_level, sda_level, sda_drive, busy_res,
//                                  done_res, nack, rx_byte
//   cfg       in    i_cfg_we       i_cfg_wdata = max_attempts
//
// One tick item per cycle while the output is not stalled.
// The tick is held in an input register, stepped through the phase logic and
// the result lands in an output register.
// Reset (synchronous): idle, SCL and SDA high with SDA driven, max_attempts 3.
// A stalled output holds the tick in the input register; input ready drops
// only while both registers are full and the output is not taken.
`default_nettype none
`include "assert_macros.svh"
module i2c_master_bit_sequencer_unit
    import i2cms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [AttemptW-1:0] i_cfg_wdata,
    i2cms_in_if.sink                 i_item,
    i2cms_out_if.source              o_item
);

    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [AttemptW-1:0] r_max_att;

    t_out_item           step_res;
    logic                out_free;
    logic                step_fire;
    logic                in_fire;

    assign out_free  = !r_out_valid || o_item.ready;
    assign step_fire = r_in_valid && out_free;
    assign in_fire   = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att <= AttemptsRst;
        end else if (i_cfg_we) begin
            r_max_att <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.cmd_valid <= i_item.cmd_valid;
            r_in.opcode    <= i_item.opcode;
            r_in.tx_byte   <= i_item.tx_byte;
            r_in.ack_flag  <= i_item.ack_flag;
            r_in.sda_in    <= i_item.sda_in;
        end
    end

    i2cms_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (step_fire),
        .i_item         (r_in),
        .i_max_attempts (r_max_att),
        .o_res          (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= step_res;
        end
    end

    assign o_item.valid     = r_out_valid;
    assign o_item.scl_level = r_out.scl_level;
    assign o_item.sda_level = r_out.sda_level;
    assign o_item.sda_drive = r_out.sda_drive;
    assign o_item.busy_res  = r_out.busy_res;
    assign o_item.done_res  = r_out.done_res;
    assign o_item.nack      = r_out.nack;
    assign o_item.rx_byte   = r_out.rx_byte;

    `CHK_HOLD(a_step_lands, i_clk, i_rst_n, step_fire |=> r_out_valid)
    `CHK_HOLD(a_in_held, i_clk, i_rst_n, (r_in_valid && !step_fire) |=> r_in_valid)
    `CHK_NEVER(a_nack_wo_done, i_clk, i_rst_n,
        r_out_valid && r_out.nack && !(r_out.done_res && r_out.busy_res))

endmodule
`default_nettype wire
